/* design/cfgov_pkg.sv */
// Shared types, constants and helper functions for the CPU frequency governor.
package cfgov_pkg;

  localparam int TICK_BITS_DEF = 32;
  localparam int IN_FIXED_BITS = 10;
  localparam int OUT_DATA_W    = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_W    = 32;
  localparam int PAIR_W        = 16;

  localparam logic [6:0] PCT_FULL    = 7'd100;
  localparam logic [6:0] LOAD_SCALE  = 7'd100;
  localparam logic [2:0] SCALE_MSB   = 3'd6;

  localparam logic [PAIR_W-1:0] MIN_RST   = 16'd0;
  localparam logic [PAIR_W-1:0] MAX_RST   = 16'd25700;
  localparam logic [PAIR_W-1:0] THR_RST   = 16'd7710;
  localparam logic [PAIR_W-1:0] UP_RST    = 16'd25700;
  localparam logic [PAIR_W-1:0] DOWN_RST  = 16'd7780;
  localparam logic [PAIR_W-1:0] INERT_RST = 16'd2565;
  localparam logic [PAIR_W-1:0] TLIM_RST  = 16'd0;

  localparam logic [1:0] PROFILE_NONE = 2'd2;

  typedef enum logic [2:0] {
    REG_MIN,
    REG_MAX,
    REG_THR,
    REG_UP,
    REG_DOWN,
    REG_INERT,
    REG_TLIM
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DBL,
    ST_ADD,
    ST_CAP,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic [PAIR_W-1:0] min_pair;
    logic [PAIR_W-1:0] max_pair;
    logic [PAIR_W-1:0] threshold_pair;
    logic [PAIR_W-1:0] up_step_pair;
    logic [PAIR_W-1:0] down_step_pair;
    logic [PAIR_W-1:0] inertia_pair;
    logic [PAIR_W-1:0] temp_limit_pair;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic dbl;
    logic add;
    logic cap;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [7:0] pick(input logic [PAIR_W-1:0] pair, input logic wall);
    return wall ? pair[15:8] : pair[7:0];
  endfunction

  function automatic logic [6:0] pct(input logic [7:0] v);
    return (v > {1'b0, PCT_FULL}) ? PCT_FULL : v[6:0];
  endfunction

endpackage

/* design/cfgov_regs.sv */
// Configuration register file behind the APB-style port.
module cfgov_regs
  import cfgov_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  reg_idx_t idx;
  logic     wr_en;
  logic [PAIR_W-1:0] rd_pair;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pair        <= MIN_RST;
      cfg.max_pair        <= MAX_RST;
      cfg.threshold_pair  <= THR_RST;
      cfg.up_step_pair    <= UP_RST;
      cfg.down_step_pair  <= DOWN_RST;
      cfg.inertia_pair    <= INERT_RST;
      cfg.temp_limit_pair <= TLIM_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN:   cfg.min_pair        <= pwdata[PAIR_W-1:0];
        REG_MAX:   cfg.max_pair        <= pwdata[PAIR_W-1:0];
        REG_THR:   cfg.threshold_pair  <= pwdata[PAIR_W-1:0];
        REG_UP:    cfg.up_step_pair    <= pwdata[PAIR_W-1:0];
        REG_DOWN:  cfg.down_step_pair  <= pwdata[PAIR_W-1:0];
        REG_INERT: cfg.inertia_pair    <= pwdata[PAIR_W-1:0];
        REG_TLIM:  cfg.temp_limit_pair <= pwdata[PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN:   rd_pair = cfg.min_pair;
      REG_MAX:   rd_pair = cfg.max_pair;
      REG_THR:   rd_pair = cfg.threshold_pair;
      REG_UP:    rd_pair = cfg.up_step_pair;
      REG_DOWN:  rd_pair = cfg.down_step_pair;
      REG_INERT: rd_pair = cfg.inertia_pair;
      REG_TLIM:  rd_pair = cfg.temp_limit_pair;
      default:   rd_pair = '0;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-PAIR_W){1'b0}}, rd_pair};

endmodule

/* design/cfgov_ctrl.sv */
// Sequencer for one governor tick: division steps, cap update, state update.
module cfgov_ctrl
  import cfgov_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state, state_next;
  logic [2:0] bit_idx, bit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_idx <= SCALE_MSB;
    end else begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          bit_idx_next = SCALE_MSB;
          state_next   = ST_DBL;
        end
      end
      ST_DBL: begin
        cmd.dbl = 1'b1;
        if (LOAD_SCALE[bit_idx]) begin
          state_next = ST_ADD;
        end else if (bit_idx == 3'd0) begin
          state_next = ST_CAP;
        end else begin
          bit_idx_next = bit_idx - 3'd1;
        end
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (bit_idx == 3'd0) begin
          state_next = ST_CAP;
        end else begin
          bit_idx_next = bit_idx - 3'd1;
          state_next   = ST_DBL;
        end
      end
      ST_CAP: begin
        cmd.cap    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (sts.out_free) begin
          cmd.upd    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* design/cfgov_dp.sv */
// Datapath: serial load divider, thermal cap, frequency and inertia state, output register.
module cfgov_dp
  import cfgov_pkg::*;
#(
  parameter int TICK_COUNT_BITS = TICK_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  cfg_t                       cfg,
  input  logic                       on_wall,
  input  logic signed [8:0]          temperature,
  input  logic [TICK_COUNT_BITS-1:0] total_ticks,
  input  logic [TICK_COUNT_BITS-1:0] idle_ticks,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [6:0]                 frequency,
  output logic                       set_request,
  output logic [6:0]                 load_percent,
  output logic [6:0]                 thermal_cap,
  output logic [7:0]                 inertia_level
);

  localparam int W = TICK_COUNT_BITS;

  // latched word
  logic              wall;
  logic signed [8:0] temp;
  logic [W-1:0]      total, idle, slack, rem;
  logic [6:0]        quo;
  logic              zero_load;

  // governor state
  logic [1:0] profile;
  logic [6:0] current_level, cap_level;
  logic [7:0] inertia_count;

  logic [W:0]   in_diff, add_diff;
  logic [W+1:0] dbl_diff;
  logic         dbl_ge, add_ge;

  assign in_diff  = {1'b0, total_ticks} - {1'b0, idle_ticks};
  assign dbl_diff = {1'b0, rem, 1'b0} - {2'b00, total};
  assign dbl_ge   = !dbl_diff[W+1];
  assign add_diff = {1'b0, rem} - {1'b0, slack};
  assign add_ge   = !add_diff[W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wall      <= on_wall;
      temp      <= temperature;
      total     <= total_ticks;
      idle      <= idle_ticks;
      slack     <= in_diff[W-1:0];
      zero_load <= (total_ticks == '0) || in_diff[W];
      rem       <= '0;
      quo       <= '0;
    end else if (cmd.dbl) begin
      quo <= {quo[5:0], dbl_ge};
      rem <= dbl_ge ? dbl_diff[W-1:0] : {rem[W-2:0], 1'b0};
    end else if (cmd.add) begin
      quo <= quo + {6'd0, add_ge};
      rem <= add_ge ? add_diff[W-1:0] : rem + idle;
    end
  end

  // selected profile
  logic [6:0] lo, hi;
  logic [7:0] thr, up, down, inert, tlim;

  assign lo    = pct(pick(cfg.min_pair, wall));
  assign hi    = pct(pick(cfg.max_pair, wall));
  assign thr   = pick(cfg.threshold_pair, wall);
  assign up    = pick(cfg.up_step_pair, wall);
  assign down  = pick(cfg.down_step_pair, wall);
  assign inert = pick(cfg.inertia_pair, wall);
  assign tlim  = pick(cfg.temp_limit_pair, wall);

  // thermal cap
  logic [6:0] cap_base, cap_next;
  logic       temp_hot;

  assign cap_base = (profile != {1'b0, wall}) ? hi : cap_level;
  assign temp_hot = temp > $signed({1'b0, tlim});

  always_comb begin
    cap_next = cap_base;
    if (tlim != 8'd0) begin
      if (temp_hot) begin
        if (cap_base > lo) cap_next = cap_base - 7'd1;
      end else begin
        if (cap_base < hi) cap_next = cap_base + 7'd1;
      end
    end
  end

  // frequency and inertia
  logic [6:0] load_val, freq_next;
  logic [7:0] inert_next;
  logic       set_next, busy;
  logic [8:0] up_sum, floor_sum;
  logic [6:0] up_cap;

  assign load_val  = zero_load ? 7'd0 : PCT_FULL - quo;
  assign busy      = {1'b0, load_val} > thr;
  assign up_sum    = {2'b00, current_level} + {1'b0, up};
  assign floor_sum = {2'b00, lo} + {1'b0, down};
  assign up_cap    = (cap_level < hi) ? cap_level : hi;

  always_comb begin
    freq_next  = current_level;
    inert_next = inertia_count;
    set_next   = 1'b0;
    priority if (busy) begin
      freq_next = (up_sum > {2'b00, up_cap}) ? up_cap : up_sum[6:0];
      if (inertia_count < inert) inert_next = inertia_count + 8'd1;
      set_next = 1'b1;
    end else if (inertia_count == 8'd0) begin
      freq_next = ({2'b00, current_level} < floor_sum) ? lo : current_level - down[6:0];
      set_next  = 1'b1;
    end else begin
      inert_next = inertia_count - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      profile       <= PROFILE_NONE;
      current_level <= 7'd0;
      cap_level     <= PCT_FULL;
      inertia_count <= 8'd0;
    end else begin
      if (cmd.cap) begin
        profile   <= {1'b0, wall};
        cap_level <= cap_next;
      end
      if (cmd.upd) begin
        current_level <= freq_next;
        inertia_count <= inert_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      frequency     <= freq_next;
      set_request   <= set_next;
      load_percent  <= load_val;
      thermal_cap   <= cap_level;
      inertia_level <= inert_next;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

/* design/cpu_frequency_governor_top.sv */
// Top level of the CPU frequency governor: stream ports, register port, sequencer and datapath.
// Each input word runs the serial load divider (7 doubling and 3 add steps), the cap step and the
// update step, which waits for a free output register; only then is a new input word taken.
// A new input word is taken while the previous result still waits on the output register.
// Reset (rst, synchronous, active high) clears the registers to defaults, the state to
// no profile loaded, level 0, cap 100, inertia 0, and empties the output.
module cpu_frequency_governor_top
  import cfgov_pkg::*;
#(
  parameter int TICK_COUNT_BITS = TICK_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // on_wall, temperature[8:0], total_ticks, idle_ticks, zero pad
  input  logic [((IN_FIXED_BITS + 2*TICK_COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // frequency[6:0], set_request, load_percent[6:0], thermal_cap[6:0], inertia_level[7:0], pad
  output logic [OUT_DATA_W-1:0]    m_tdata,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready
);

  localparam int W = TICK_COUNT_BITS;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  logic [6:0] frequency, load_percent, thermal_cap;
  logic       set_request;
  logic [7:0] inertia_level;

  cfgov_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfgov_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfgov_dp #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg           (cfg),
    .on_wall       (s_tdata[0]),
    .temperature   ($signed(s_tdata[9:1])),
    .total_ticks   (s_tdata[IN_FIXED_BITS +: W]),
    .idle_ticks    (s_tdata[IN_FIXED_BITS + W +: W]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .frequency     (frequency),
    .set_request   (set_request),
    .load_percent  (load_percent),
    .thermal_cap   (thermal_cap),
    .inertia_level (inertia_level)
  );

  assign m_tdata = {2'b00, inertia_level, thermal_cap, load_percent, set_request, frequency};

endmodule

/* design/cfgov_checker.sv */
// Port-level assertions for the CPU frequency governor, bound to the top level.
module cfgov_checker
  import cfgov_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after a word");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] <= PCT_FULL) && (m_tdata[14:8] <= PCT_FULL)
                 && (m_tdata[21:15] <= PCT_FULL))
    else $error("percent field above 100");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind cpu_frequency_governor_top cfgov_checker u_cfgov_checker (.*);

/* dv/tb_cpu_frequency_governor_top.sv */
// Testbench for the CPU frequency governor: directed and random ticks, checked word by word.
`timescale 1ns / 1ps

typedef logic [((cfgov_pkg::IN_FIXED_BITS + 2*cfgov_pkg::TICK_BITS_DEF + 7) / 8) * 8 - 1:0]
  tick_word_t;

typedef struct packed {
  logic [7:0] inertia_level;
  logic [6:0] thermal_cap;
  logic [6:0] load_percent;
  logic       set_request;
  logic [6:0] frequency;
} governor_report_t;

class governor_tracker;
  logic [15:0] regs [7];
  int profile;
  int level;
  int cap;
  int inertia;
  int errors;
  governor_report_t pending [$];

  function new();
    regs[cfgov_pkg::REG_MIN]   = cfgov_pkg::MIN_RST;
    regs[cfgov_pkg::REG_MAX]   = cfgov_pkg::MAX_RST;
    regs[cfgov_pkg::REG_THR]   = cfgov_pkg::THR_RST;
    regs[cfgov_pkg::REG_UP]    = cfgov_pkg::UP_RST;
    regs[cfgov_pkg::REG_DOWN]  = cfgov_pkg::DOWN_RST;
    regs[cfgov_pkg::REG_INERT] = cfgov_pkg::INERT_RST;
    regs[cfgov_pkg::REG_TLIM]  = cfgov_pkg::TLIM_RST;
    profile = int'(cfgov_pkg::PROFILE_NONE);
    level = 0;
    cap = 100;
    inertia = 0;
    errors = 0;
  endfunction

  function void set_reg(cfgov_pkg::reg_idx_t r, logic [15:0] v);
    regs[r] = v;
  endfunction

  function int side(cfgov_pkg::reg_idx_t r, bit wall);
    return wall ? int'(regs[r][15:8]) : int'(regs[r][7:0]);
  endfunction

  function int clamp_pct(int v);
    return (v > 100) ? 100 : v;
  endfunction

  function void note_tick(tick_word_t word);
    bit wall;
    int temp, lo, hi, thr, up, down, inert, tlim, load, f;
    longint unsigned total, idle;
    bit set;
    governor_report_t rep;
    wall  = word[0];
    temp  = int'($signed(word[9:1]));
    total = word[41:10];
    idle  = word[73:42];
    lo    = clamp_pct(side(cfgov_pkg::REG_MIN, wall));
    hi    = clamp_pct(side(cfgov_pkg::REG_MAX, wall));
    thr   = side(cfgov_pkg::REG_THR, wall);
    up    = side(cfgov_pkg::REG_UP, wall);
    down  = side(cfgov_pkg::REG_DOWN, wall);
    inert = side(cfgov_pkg::REG_INERT, wall);
    tlim  = side(cfgov_pkg::REG_TLIM, wall);
    set   = 0;
    if (profile != int'(wall)) begin
      profile = int'(wall);
      cap = hi;
    end
    if (tlim != 0) begin
      if (temp > tlim) begin
        if (cap > lo) cap--;
      end else if (cap < hi) begin
        cap++;
      end
    end
    if (total == 0 || idle > total) begin
      load = 0;
    end else begin
      load = 100 - int'((64'd100 * idle) / total);
    end
    if (load > thr) begin
      f = level + up;
      if (f > cap) f = cap;
      if (f > hi) f = hi;
      level = f;
      if (inertia < inert) inertia++;
      set = 1;
    end else if (inertia == 0) begin
      level = (level < lo + down) ? lo : level - down;
      set = 1;
    end else begin
      inertia--;
    end
    rep.frequency     = 7'(level);
    rep.set_request   = set;
    rep.load_percent  = 7'(load);
    rep.thermal_cap   = 7'(cap);
    rep.inertia_level = 8'(inertia);
    pending.push_back(rep);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [31:0] word);
    governor_report_t got, want;
    got = governor_report_t'(word[29:0]);
    if (pending.size() == 0) begin
      $error("result word %h with no tick pending", word);
      errors++;
      return;
    end
    want = pending.pop_front();
    compare_field("frequency", 8'(want.frequency), 8'(got.frequency));
    compare_field("set_request", 8'(want.set_request), 8'(got.set_request));
    compare_field("load_percent", 8'(want.load_percent), 8'(got.load_percent));
    compare_field("thermal_cap", 8'(want.thermal_cap), 8'(got.thermal_cap));
    compare_field("inertia_level", want.inertia_level, got.inertia_level);
  endfunction
endclass

module tb_cpu_frequency_governor_top;
  import cfgov_pkg::*;

  localparam int ITEMS_PER_PHASE = 240;
  localparam int RANDOM_PHASES   = 6;
  localparam int HOLD_AT         = 700;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 24;
  localparam int STALL_LIMIT     = 4000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  tick_word_t               s_tdata;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_DATA_W-1:0]    m_tdata;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_W-1:0]    pwdata;
  logic [CFG_DATA_W-1:0]    prdata;
  logic                     pready;

  governor_tracker tracker;
  int n_sent = 0;
  int quiet_cycles = 0;
  int burst_left = 8;
  bit wall_now = 0;

  cpu_frequency_governor_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  function automatic tick_word_t pack_tick(bit wall, logic [8:0] temp, logic [31:0] total,
                                           logic [31:0] idle);
    return tick_word_t'({idle, total, temp, wall});
  endfunction

  function automatic tick_word_t random_tick();
    int t, tlim;
    logic [8:0] traw;
    logic [31:0] total, idle;
    if ($urandom_range(0, 15) == 0) wall_now = !wall_now;
    tlim = tracker.side(REG_TLIM, wall_now);
    if ($urandom_range(0, 2) == 0) begin
      traw = 9'($urandom);
    end else begin
      t = tlim + int'($urandom_range(0, 6)) - 3;
      if (t > 255) t = 255;
      traw = 9'(t);
    end
    case ($urandom_range(0, 9))
      0: begin
        total = 0;
        idle = $urandom;
      end
      1: begin
        total = $urandom_range(0, 32'hFFFF_FFFE);
        idle = $urandom_range(total + 1, 32'hFFFF_FFFF);
      end
      2: begin
        total = $urandom;
        idle = total;
      end
      3: begin
        total = $urandom;
        idle = 0;
      end
      4, 5, 6: begin
        total = $urandom_range(1, 1000);
        idle = $urandom_range(0, total);
      end
      default: begin
        total = $urandom;
        idle = $urandom_range(0, total);
      end
    endcase
    return pack_tick(wall_now, traw, total, idle);
  endfunction

  function automatic logic [7:0] cfg_byte(reg_idx_t r);
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = 8'd0;
      1: b = 8'hFF;
      2: b = 8'($urandom_range(101, 254));
      default: begin
        case (r)
          REG_MIN:          b = 8'($urandom_range(0, 60));
          REG_MAX:          b = 8'($urandom_range(40, 100));
          REG_THR:          b = 8'($urandom_range(10, 90));
          REG_UP, REG_DOWN: b = 8'($urandom_range(1, 50));
          REG_INERT:        b = 8'($urandom_range(0, 12));
          default:          b = 8'($urandom_range(30, 90));
        endcase
      end
    endcase
    return b;
  endfunction

  task automatic write_reg(reg_idx_t r, logic [15:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(r, v);
  endtask

  task automatic close_cfg();
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic pause_send(int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tdata  <= tick_word_t'({$urandom, $urandom, $urandom});
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic feed_tick(tick_word_t w);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    tracker.note_tick(w);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) pause_send($urandom_range(1, 25));
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic finish_phase();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: changing stall modes plus one long hold-off to back up the input
  initial begin : result_sink
    int mode, mode_left, hold_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    tracker  = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // default registers: zero total, idle above total, full and empty load, source switch
    feed_tick(pack_tick(1'b0, 9'd0, 32'd0, 32'd0));
    feed_tick(pack_tick(1'b0, 9'h0FF, 32'd10, 32'd11));
    feed_tick(pack_tick(1'b0, 9'h100, 32'hFFFF_FFFF, 32'd0));
    feed_tick(pack_tick(1'b0, 9'd25, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    feed_tick(pack_tick(1'b1, 9'd60, 32'd3, 32'd1));
    feed_tick(pack_tick(1'b1, 9'd60, 32'd3, 32'd2));
    feed_tick(pack_tick(1'b1, 9'd60, 32'd100, 32'd70));
    repeat (4) feed_tick(pack_tick(1'b1, 9'd60, 32'd1000, 32'd1000));
    finish_phase();

    // percent above hundred, minimum above maximum, zero steps, threshold out of reach
    write_reg(REG_MIN, 16'h3CC8);
    write_reg(REG_MAX, 16'hFF05);
    write_reg(REG_THR, 16'h00FF);
    write_reg(REG_UP, 16'h0000);
    write_reg(REG_DOWN, 16'h0000);
    write_reg(REG_INERT, 16'hFF00);
    write_reg(REG_TLIM, 16'h28FF);
    close_cfg();
    feed_tick(pack_tick(1'b0, 9'h0FF, 32'd5, 32'd0));
    feed_tick(pack_tick(1'b0, 9'h100, 32'd5, 32'd0));
    feed_tick(pack_tick(1'b0, 9'h0FF, 32'd5, 32'd5));
    feed_tick(pack_tick(1'b1, 9'd41, 32'd7, 32'd3));
    feed_tick(pack_tick(1'b1, 9'd41, 32'd7, 32'd3));
    feed_tick(pack_tick(1'b1, 9'd41, 32'd7, 32'd7));
    feed_tick(pack_tick(1'b1, 9'd40, 32'd7, 32'd3));
    feed_tick(pack_tick(1'b1, 9'd39, 32'd7, 32'd3));
    feed_tick(pack_tick(1'b1, 9'h1FF, 32'd0, 32'd3));
    feed_tick(pack_tick(1'b1, 9'h0FF, 32'd7, 32'd0));
    feed_tick(pack_tick(1'b1, 9'h100, 32'd7, 32'd0));
    finish_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int r = 0; r < 7; r++) begin
        if (p == 0) write_reg(reg_idx_t'(r), 16'h0000);
        else if (p == 1) write_reg(reg_idx_t'(r), 16'hFFFF);
        else write_reg(reg_idx_t'(r), {cfg_byte(reg_idx_t'(r)), cfg_byte(reg_idx_t'(r))});
      end
      close_cfg();
      repeat (ITEMS_PER_PHASE) feed_tick(random_tick());
      finish_phase();
    end

    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
